// ===== hdl/dtmf_pkg.sv =====
// ----------------------------------------------------------------------------
// dtmf_pkg
// Shared constants, types and table functions for the DTMF tone generator.
// ----------------------------------------------------------------------------
package dtmf_pkg;

    localparam int DEF_SAMPLE_RATE    = 44100;
    localparam int DEF_PHASE_BITS     = 32;
    localparam int DEF_SINE_ADDR_BITS = 10;

    localparam int SYM_W    = 8;
    localparam int SAMPLE_W = 16;
    localparam int PLEN_W   = 16;
    localparam int SEL_W    = 3;
    localparam int FULL_W   = 14;
    localparam int HALF_W   = 13;
    localparam int ROM_W    = FULL_W + HALF_W;

    localparam logic [PLEN_W-1:0] PLEN_RESET = 16'd4410;

    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
    localparam longint unsigned FULL_AMP    = 64'd10000;
    localparam longint unsigned HALF_AMP    = 64'd5000;

    localparam logic [SEL_W-1:0] SEL_NONE = 3'd0;
    localparam logic [SEL_W-1:0] SEL_1    = 3'd1;
    localparam logic [SEL_W-1:0] SEL_2    = 3'd2;
    localparam logic [SEL_W-1:0] SEL_3    = 3'd3;
    localparam logic [SEL_W-1:0] SEL_4    = 3'd4;
    localparam logic [SEL_W-1:0] SEL_SLOW = 3'd5;

    localparam int LO_FREQ [4] = '{697, 770, 852, 941};
    localparam int HI_FREQ [4] = '{1209, 1336, 1477, 1633};
    localparam int SLOW_FREQ   = 300;

    localparam logic [SYM_W-1:0] SYM_SLOW = "S";

    localparam longint unsigned TAYLOR_DIV [5] = '{64'd6, 64'd20, 64'd42, 64'd72, 64'd110};

    typedef struct packed {
        logic             valid;
        logic [SEL_W-1:0] lo_sel;
        logic [SEL_W-1:0] hi_sel;
    } tone_pair_t;

    typedef struct packed {
        logic lo_on;
        logic lo_neg;
        logic lo_half;
        logic hi_on;
        logic hi_neg;
        logic hi_half;
        logic last;
    } tap_info_t;

    function automatic tone_pair_t dtmf_decode(input logic [SYM_W-1:0] code);
        tone_pair_t p;
        p.valid  = 1'b1;
        p.lo_sel = SEL_NONE;
        p.hi_sel = SEL_NONE;
        case (code) inside
            "1", "2", "3", "a": p.lo_sel = SEL_1;
            "4", "5", "6", "b": p.lo_sel = SEL_2;
            "7", "8", "9", "c": p.lo_sel = SEL_3;
            "*", "0", "#", "d": p.lo_sel = SEL_4;
            default:            p.lo_sel = SEL_NONE;
        endcase
        case (code) inside
            "1", "4", "7", "*": p.hi_sel = SEL_1;
            "2", "5", "8", "0": p.hi_sel = SEL_2;
            "3", "6", "9", "#": p.hi_sel = SEL_3;
            "a", "b", "c", "d": p.hi_sel = SEL_4;
            default:            p.hi_sel = SEL_NONE;
        endcase
        if (code == SYM_SLOW) begin
            p.lo_sel = SEL_SLOW;
            p.hi_sel = SEL_SLOW;
        end else if (p.lo_sel == SEL_NONE) begin
            p.valid = 1'b0;
        end
        return p;
    endfunction

    // Q30 sine, Taylor series to x^11
    function automatic longint unsigned sine_q30(input longint unsigned x);
        longint unsigned x2;
        longint unsigned term;
        longint          sum;
        x2   = (x * x) >> 30;
        term = x;
        sum  = longint'(x);
        for (int k = 0; k < 5; k++) begin
            term = ((term * x2) >> 30) / TAYLOR_DIV[k];
            if ((k % 2) == 0)
                sum = sum - longint'(term);
            else
                sum = sum + longint'(term);
        end
        return (sum < 0) ? 64'd0 : longint'(sum);
    endfunction

    // Quarter-wave magnitude at index r, rounded half up
    function automatic longint unsigned tone_mag(input int r, input int qb,
                                                 input longint unsigned amp);
        longint unsigned x;
        x = (longint'(r) * HALF_PI_Q30 + (64'd1 << (qb - 1))) >> qb;
        return (amp * sine_q30(x) + (64'd1 << 29)) >> 30;
    endfunction

endpackage

// ===== hdl/dtmf_sine_rom.sv =====
// ----------------------------------------------------------------------------
// dtmf_sine_rom
// Quarter-wave sine ROM, full and half amplitude per word, registered read.
// ----------------------------------------------------------------------------
module dtmf_sine_rom
    import dtmf_pkg::*;
#(
    parameter int QUARTER_BITS = DEF_SINE_ADDR_BITS - 2
)
(
    input  logic                    clk,
    input  logic                    en,
    input  logic [QUARTER_BITS:0]   addr,
    output logic [ROM_W-1:0]        data
);

    localparam int DEPTH = (1 << QUARTER_BITS) + 1;

    logic [ROM_W-1:0] rom [DEPTH];
    logic [ROM_W-1:0] data_reg;

    for (genvar i = 0; i < DEPTH; i++) begin : g_tab
        assign rom[i] = {HALF_W'(tone_mag(i, QUARTER_BITS, HALF_AMP)),
                         FULL_W'(tone_mag(i, QUARTER_BITS, FULL_AMP))};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            data_reg <= rom[addr];
        end
    end

    assign data = data_reg;

endmodule

// ===== hdl/dtmf_phase_ctrl.sv =====
// ----------------------------------------------------------------------------
// dtmf_phase_ctrl
// Symbol latch, phase accumulators, packet position and ROM address issue.
// ----------------------------------------------------------------------------
module dtmf_phase_ctrl
    import dtmf_pkg::*;
#(
    parameter int SAMPLE_RATE    = DEF_SAMPLE_RATE,
    parameter int PHASE_BITS     = DEF_PHASE_BITS,
    parameter int SINE_ADDR_BITS = DEF_SINE_ADDR_BITS
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_valid,
    input  logic [PLEN_W-1:0]           cfg_data,
    input  logic                        in_valid,
    input  logic                        in_take,
    input  logic                        in_kind,
    input  logic [SYM_W-1:0]            in_code,
    output logic                        issue,
    output tap_info_t                   issue_info,
    output logic [SINE_ADDR_BITS-2:0]   lo_addr,
    output logic [SINE_ADDR_BITS-2:0]   hi_addr
);

    localparam int QB = SINE_ADDR_BITS - 2;
    localparam logic [QB:0] QMAX = {1'b1, {QB{1'b0}}};

    function automatic logic [PHASE_BITS-1:0] phase_inc(input int f);
        return PHASE_BITS'(((64'(f) << PHASE_BITS) + 64'(SAMPLE_RATE / 2))
                           / 64'(SAMPLE_RATE));
    endfunction

    localparam logic [PHASE_BITS-1:0] LO_INC [4] = '{
        phase_inc(LO_FREQ[0]), phase_inc(LO_FREQ[1]),
        phase_inc(LO_FREQ[2]), phase_inc(LO_FREQ[3])};
    localparam logic [PHASE_BITS-1:0] HI_INC [4] = '{
        phase_inc(HI_FREQ[0]), phase_inc(HI_FREQ[1]),
        phase_inc(HI_FREQ[2]), phase_inc(HI_FREQ[3])};
    localparam logic [PHASE_BITS-1:0] SLOW_INC = phase_inc(SLOW_FREQ);

    logic [PLEN_W-1:0]     plen_reg;
    logic [SEL_W-1:0]      lo_sel_reg, lo_sel_next;
    logic [SEL_W-1:0]      hi_sel_reg, hi_sel_next;
    logic [PHASE_BITS-1:0] lo_phase_reg, lo_phase_next;
    logic [PHASE_BITS-1:0] hi_phase_reg, hi_phase_next;
    logic [PLEN_W-1:0]     pos_reg, pos_next;

    logic                  accept;
    tone_pair_t            pair;
    logic [PHASE_BITS-1:0] lo_inc, hi_inc;
    logic                  lo_on, hi_on;
    logic [PLEN_W-1:0]     pos_inc;
    logic                  last;
    logic [SINE_ADDR_BITS-1:0] lo_top, hi_top;

    function automatic logic [PHASE_BITS-1:0] pick_inc(input logic [SEL_W-1:0] sel,
                                                       input logic hi);
        logic [PHASE_BITS-1:0] v;
        case (sel)
            SEL_1:    v = hi ? HI_INC[0] : LO_INC[0];
            SEL_2:    v = hi ? HI_INC[1] : LO_INC[1];
            SEL_3:    v = hi ? HI_INC[2] : LO_INC[2];
            SEL_4:    v = hi ? HI_INC[3] : LO_INC[3];
            SEL_SLOW: v = SLOW_INC;
            default:  v = '0;
        endcase
        return v;
    endfunction

    function automatic logic [QB:0] fold(input logic [SINE_ADDR_BITS-1:0] a);
        logic [QB:0] r;
        r = {1'b0, a[QB-1:0]};
        return a[QB] ? (QMAX - r) : r;
    endfunction

    assign accept = in_valid & in_take;
    assign issue  = accept & in_kind;
    assign pair   = dtmf_decode(in_code);

    always_comb
    begin
        lo_on   = (lo_sel_reg >= SEL_1) && (lo_sel_reg <= SEL_SLOW);
        hi_on   = (hi_sel_reg >= SEL_1) && (hi_sel_reg <= SEL_SLOW);
        lo_inc  = pick_inc(lo_sel_reg, 1'b0);
        hi_inc  = pick_inc(hi_sel_reg, 1'b1);
        pos_inc = pos_reg + 1'b1;
        last    = (pos_inc == plen_reg);
        lo_top  = lo_phase_reg[PHASE_BITS-1 -: SINE_ADDR_BITS];
        hi_top  = hi_phase_reg[PHASE_BITS-1 -: SINE_ADDR_BITS];

        lo_sel_next   = lo_sel_reg;
        hi_sel_next   = hi_sel_reg;
        lo_phase_next = lo_phase_reg;
        hi_phase_next = hi_phase_reg;
        pos_next      = pos_reg;
        if (accept && !in_kind)
        begin
            if (pair.valid)
            begin
                lo_sel_next = pair.lo_sel;
                hi_sel_next = pair.hi_sel;
            end
            lo_phase_next = '0;
            hi_phase_next = '0;
            pos_next      = '0;
        end
        else if (issue)
        begin
            lo_phase_next = lo_phase_reg + lo_inc;
            hi_phase_next = hi_phase_reg + hi_inc;
            pos_next      = last ? '0 : pos_inc;
        end

        issue_info.lo_on   = lo_on;
        issue_info.lo_neg  = lo_top[SINE_ADDR_BITS-1];
        issue_info.lo_half = (lo_sel_reg == SEL_SLOW);
        issue_info.hi_on   = hi_on;
        issue_info.hi_neg  = hi_top[SINE_ADDR_BITS-1];
        issue_info.hi_half = (hi_sel_reg == SEL_SLOW);
        issue_info.last    = last;
        lo_addr = fold(lo_top);
        hi_addr = fold(hi_top);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            plen_reg     <= PLEN_RESET;
            lo_sel_reg   <= SEL_NONE;
            hi_sel_reg   <= SEL_NONE;
            lo_phase_reg <= '0;
            hi_phase_reg <= '0;
            pos_reg      <= '0;
        end
        else
        begin
            if (cfg_valid)
            begin
                plen_reg <= cfg_data;
            end
            lo_sel_reg   <= lo_sel_next;
            hi_sel_reg   <= hi_sel_next;
            lo_phase_reg <= lo_phase_next;
            hi_phase_reg <= hi_phase_next;
            pos_reg      <= pos_next;
        end
    end

endmodule

// ===== hdl/dtmf_out_stage.sv =====
// ----------------------------------------------------------------------------
// dtmf_out_stage
// Sign and sum of the two tone reads, output register and flow control.
// ----------------------------------------------------------------------------
module dtmf_out_stage
    import dtmf_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                issue,
    input  tap_info_t           issue_info,
    input  logic [ROM_W-1:0]    lo_word,
    input  logic [ROM_W-1:0]    hi_word,
    output logic                take,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [SAMPLE_W-1:0] m_tdata,
    output logic                m_tlast
);

    logic                p1_valid_reg, p1_valid_next;
    tap_info_t           info_reg;
    logic                out_valid_reg, out_valid_next;
    logic [SAMPLE_W-1:0] data_reg;
    logic                last_reg;
    logic                p1_move;
    logic signed [FULL_W:0]   lo_val, hi_val;
    logic signed [SAMPLE_W-1:0] sum;

    function automatic logic signed [FULL_W:0] tone_val(input logic [ROM_W-1:0] w,
                                                        input logic on,
                                                        input logic neg,
                                                        input logic half);
        logic [FULL_W-1:0]      mag;
        logic signed [FULL_W:0] v;
        mag = half ? {1'b0, w[ROM_W-1 -: HALF_W]} : w[FULL_W-1:0];
        v   = $signed({1'b0, mag});
        if (!on)
            v = '0;
        else if (neg)
            v = -v;
        return v;
    endfunction

    always_comb
    begin
        p1_move = p1_valid_reg && (!out_valid_reg || m_tready);
        take    = !p1_valid_reg || p1_move;
        lo_val  = tone_val(lo_word, info_reg.lo_on, info_reg.lo_neg, info_reg.lo_half);
        hi_val  = tone_val(hi_word, info_reg.hi_on, info_reg.hi_neg, info_reg.hi_half);
        sum     = $signed({lo_val[FULL_W], lo_val}) + $signed({hi_val[FULL_W], hi_val});

        p1_valid_next = issue ? 1'b1 : (p1_move ? 1'b0 : p1_valid_reg);
        out_valid_next = p1_move ? 1'b1 : (m_tready ? 1'b0 : out_valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            p1_valid_reg  <= p1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            info_reg <= issue_info;
        end
        if (p1_move)
        begin
            data_reg <= sum;
            last_reg <= info_reg.last;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = data_reg;
    assign m_tlast  = last_reg;

endmodule

// ===== hdl/dtmf_tone_generator_top.sv =====
// ----------------------------------------------------------------------------
// dtmf_tone_generator_top
// DTMF generator: keypad symbol loads and one two-tone sample per request.
// ----------------------------------------------------------------------------
// One input word per clock while the output side keeps tready high. A word
// with tuser = 0 loads the symbol in tdata and makes no output; a word with
// tuser = 1 makes one sample word, through the sine ROM registered read and
// then the output register. The phase add and the ROM read of each tone
// path fit in the accept cycle, so samples stream back to back. The packet
// length register may be written at any time the block is idle; it is
// always ready. No clearing pass after reset.
module dtmf_tone_generator_top
    import dtmf_pkg::*;
#(
    parameter int SAMPLE_RATE    = DEF_SAMPLE_RATE,
    parameter int PHASE_BITS     = DEF_PHASE_BITS,
    parameter int SINE_ADDR_BITS = DEF_SINE_ADDR_BITS
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [PLEN_W-1:0]   cfg_data,    // packet_length
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [SYM_W-1:0]    s_tdata,     // symbol_code
    input  logic [0:0]          s_tuser,     // req_type
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [SAMPLE_W-1:0] m_tdata,     // sample
    output logic                m_tlast      // last_of_symbol
);

    logic                      take;
    logic                      issue;
    tap_info_t                 issue_info;
    logic [SINE_ADDR_BITS-2:0] lo_addr, hi_addr;
    logic [ROM_W-1:0]          lo_word, hi_word;

    assign cfg_ready = 1'b1;
    assign s_tready  = take;

    dtmf_phase_ctrl #(
        .SAMPLE_RATE    (SAMPLE_RATE),
        .PHASE_BITS     (PHASE_BITS),
        .SINE_ADDR_BITS (SINE_ADDR_BITS)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_data   (cfg_data),
        .in_valid   (s_tvalid),
        .in_take    (take),
        .in_kind    (s_tuser[0]),
        .in_code    (s_tdata),
        .issue      (issue),
        .issue_info (issue_info),
        .lo_addr    (lo_addr),
        .hi_addr    (hi_addr)
    );

    dtmf_sine_rom #(
        .QUARTER_BITS (SINE_ADDR_BITS - 2)
    ) u_lo_rom (
        .clk  (clk),
        .en   (issue),
        .addr (lo_addr),
        .data (lo_word)
    );

    dtmf_sine_rom #(
        .QUARTER_BITS (SINE_ADDR_BITS - 2)
    ) u_hi_rom (
        .clk  (clk),
        .en   (issue),
        .addr (hi_addr),
        .data (hi_word)
    );

    dtmf_out_stage u_out (
        .clk        (clk),
        .rst_n      (rst_n),
        .issue      (issue),
        .issue_info (issue_info),
        .lo_word    (lo_word),
        .hi_word    (hi_word),
        .take       (take),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast)
    );

endmodule

// ===== tb/dtmf_tone_generator_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtmf_tone_generator_top_tb
// Self-checking bench for the DTMF tone generator.
// Symbol loads and sample requests go in on the slave stream. Every sample
// word coming back is compared with a bit-exact software model of both tone
// paths: phase accumulators, quarter-wave sine and packet position. A short
// directed table comes first, then random symbol bursts over several packet
// lengths and idle patterns, then short runs with the length lowered below
// the position and with zero length.
// ----------------------------------------------------------------------------
module dtmf_tone_generator_top_tb;
    import dtmf_pkg::*;

    typedef longint unsigned u64_t;

    localparam logic REQ_LOAD   = 1'b0;
    localparam logic REQ_SAMPLE = 1'b1;

    localparam int RATE        = DEF_SAMPLE_RATE;
    localparam int PH_BITS     = DEF_PHASE_BITS;
    localparam int ADDR_BITS   = DEF_SINE_ADDR_BITS;
    localparam int QB          = ADDR_BITS - 2;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int MAX_PRINTS  = 50;

    typedef struct {
        logic [SAMPLE_W-1:0] level;
        logic                last;
    } sample_word_t;

    typedef struct {
        logic                req;
        logic [SYM_W-1:0]    code;
        bit                  typed;
        logic [SAMPLE_W-1:0] level;
        logic                last;
    } stim_row_t;

    logic                clk;
    logic                rst_n;
    logic                cfg_valid;
    logic                cfg_ready;
    logic [PLEN_W-1:0]   cfg_data;
    logic                s_tvalid;
    logic                s_tready;
    logic [SYM_W-1:0]    s_tdata;
    logic [0:0]          s_tuser;
    logic                m_tvalid;
    logic                m_tready;
    logic [SAMPLE_W-1:0] m_tdata;
    logic                m_tlast;

    // tone model state
    logic [SEL_W-1:0]   row_sel;
    logic [SEL_W-1:0]   col_sel;
    logic [PH_BITS-1:0] row_phase;
    logic [PH_BITS-1:0] col_phase;
    logic [PLEN_W-1:0]  sym_pos;
    logic [PLEN_W-1:0]  pkt_len;

    sample_word_t pending_samples [$];
    sample_word_t oldest_sample;
    int           mismatch_count;
    int           samples_seen;
    int           cycle_count;
    int           send_idle_pct;
    int           recv_idle_pct;
    string        keypad_keys = "0123456789*#abcdS";

    stim_row_t stim_rows [25] = '{
        '{REQ_SAMPLE, 8'h00, 1'b1, 16'd0, 1'b0},
        '{REQ_SAMPLE, 8'hFF, 1'b1, 16'd0, 1'b0},
        '{REQ_LOAD,   8'h00, 1'b0, 16'd0, 1'b0},
        '{REQ_SAMPLE, 8'h5A, 1'b1, 16'd0, 1'b0},
        '{REQ_LOAD,   8'hFF, 1'b0, 16'd0, 1'b0},
        '{REQ_SAMPLE, 8'hA5, 1'b1, 16'd0, 1'b0},
        '{REQ_LOAD,   "1",   1'b0, 16'd0, 1'b0},
        '{REQ_SAMPLE, 8'h00, 1'b1, 16'd0, 1'b0},
        '{REQ_SAMPLE, 8'h00, 1'b0, 16'd0, 1'b0},
        '{REQ_SAMPLE, 8'h00, 1'b0, 16'd0, 1'b0},
        '{REQ_LOAD,   SYM_SLOW, 1'b0, 16'd0, 1'b0},
        '{REQ_SAMPLE, 8'h00, 1'b1, 16'd0, 1'b0},
        '{REQ_SAMPLE, 8'h00, 1'b0, 16'd0, 1'b0},
        '{REQ_LOAD,   "q",   1'b0, 16'd0, 1'b0},
        '{REQ_SAMPLE, 8'h00, 1'b1, 16'd0, 1'b0},
        '{REQ_SAMPLE, 8'h00, 1'b0, 16'd0, 1'b0},
        '{REQ_LOAD,   "d",   1'b0, 16'd0, 1'b0},
        '{REQ_SAMPLE, 8'h00, 1'b1, 16'd0, 1'b0},
        '{REQ_SAMPLE, 8'h00, 1'b0, 16'd0, 1'b0},
        '{REQ_LOAD,   "*",   1'b0, 16'd0, 1'b0},
        '{REQ_SAMPLE, 8'h00, 1'b1, 16'd0, 1'b0},
        '{REQ_SAMPLE, 8'h00, 1'b0, 16'd0, 1'b0},
        '{REQ_LOAD,   "#",   1'b0, 16'd0, 1'b0},
        '{REQ_SAMPLE, 8'h00, 1'b1, 16'd0, 1'b0},
        '{REQ_SAMPLE, 8'h00, 1'b0, 16'd0, 1'b0}
    };

    dtmf_tone_generator_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Q30 sine, Taylor series through x^11
    function automatic u64_t taylor_sin_q30(input u64_t x);
        u64_t   x_sq;
        u64_t   t;
        longint acc;
        x_sq = (x * x) >> 30;
        t    = x;
        acc  = longint'(x);
        for (int n = 1; n <= 5; n++)
        begin
            t = ((t * x_sq) >> 30) / u64_t'((2 * n) * (2 * n + 1));
            if ((n % 2) == 1)
                acc = acc - longint'(t);
            else
                acc = acc + longint'(t);
        end
        return (acc < 0) ? u64_t'(0) : u64_t'(acc);
    endfunction

    function automatic int tone_level(input logic [PH_BITS-1:0] ph, input u64_t amp);
        u64_t addr;
        u64_t quad;
        u64_t r;
        u64_t x;
        u64_t mag;
        addr = u64_t'(ph) >> (PH_BITS - ADDR_BITS);
        quad = (addr >> QB) & 3;
        r    = addr & ((u64_t'(1) << QB) - 1);
        if ((quad & 1) != 0)
            r = (u64_t'(1) << QB) - r;
        x   = (r * HALF_PI_Q30 + (u64_t'(1) << (QB - 1))) >> QB;
        mag = (amp * taylor_sin_q30(x) + (u64_t'(1) << 29)) >> 30;
        return (quad >= 2) ? -int'(mag) : int'(mag);
    endfunction

    function automatic int tone_freq(input logic [SEL_W-1:0] sel, input bit is_col);
        case (sel)
            SEL_1, SEL_2, SEL_3, SEL_4:
                return is_col ? HI_FREQ[sel - 1] : LO_FREQ[sel - 1];
            SEL_SLOW:
                return SLOW_FREQ;
            default:
                return 0;
        endcase
    endfunction

    function automatic u64_t phase_inc(input int f);
        return ((u64_t'(f) << PH_BITS) + u64_t'(RATE / 2)) / u64_t'(RATE);
    endfunction

    task automatic load_tones(input logic [SYM_W-1:0] code);
        logic [SEL_W-1:0] row;
        logic [SEL_W-1:0] col;
        row = SEL_NONE;
        col = SEL_NONE;
        case (code)
            "1", "2", "3", "a": row = SEL_1;
            "4", "5", "6", "b": row = SEL_2;
            "7", "8", "9", "c": row = SEL_3;
            "*", "0", "#", "d": row = SEL_4;
            default:            row = SEL_NONE;
        endcase
        case (code)
            "1", "4", "7", "*": col = SEL_1;
            "2", "5", "8", "0": col = SEL_2;
            "3", "6", "9", "#": col = SEL_3;
            "a", "b", "c", "d": col = SEL_4;
            default:            col = SEL_NONE;
        endcase
        if (code == SYM_SLOW)
        begin
            row_sel = SEL_SLOW;
            col_sel = SEL_SLOW;
        end
        else if (row != SEL_NONE && col != SEL_NONE)
        begin
            row_sel = row;
            col_sel = col;
        end
        // unknown codes keep the pair but still restart
        row_phase = '0;
        col_phase = '0;
        sym_pos   = '0;
    endtask

    task automatic next_sample(output sample_word_t w);
        int                f;
        int                sum;
        logic [PLEN_W-1:0] nxt;
        sum = 0;
        f   = tone_freq(row_sel, 1'b0);
        if (f != 0)
        begin
            sum       = sum + tone_level(row_phase, (row_sel == SEL_SLOW) ? HALF_AMP : FULL_AMP);
            row_phase = row_phase + PH_BITS'(phase_inc(f));
        end
        f = tone_freq(col_sel, 1'b1);
        if (f != 0)
        begin
            sum       = sum + tone_level(col_phase, (col_sel == SEL_SLOW) ? HALF_AMP : FULL_AMP);
            col_phase = col_phase + PH_BITS'(phase_inc(f));
        end
        nxt     = sym_pos + 1'b1;
        w.last  = (nxt == pkt_len);
        sym_pos = w.last ? '0 : nxt;
        w.level = sum[SAMPLE_W-1:0];
    endtask

    task automatic report_mismatch(input string msg);
        if (mismatch_count < MAX_PRINTS)
            $display("tb: mismatch at word %0d: %s", samples_seen, msg);
        mismatch_count++;
    endtask

    task automatic send_word(input logic req, input logic [SYM_W-1:0] code, input bit typed,
                             input logic [SAMPLE_W-1:0] t_level, input logic t_last,
                             output logic last_out);
        sample_word_t w;
        @(negedge clk);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= req;
        s_tdata  <= code;
        do
            @(posedge clk);
        while (s_tready !== 1'b1);
        last_out = 1'b0;
        if (req == REQ_LOAD)
            load_tones(code);
        else
        begin
            next_sample(w);
            last_out = w.last;
            if (typed)
            begin
                w.level = t_level;
                w.last  = t_last;
            end
            pending_samples = {pending_samples, w};
        end
    endtask

    task automatic send_load(input logic [SYM_W-1:0] code);
        logic unused;
        send_word(REQ_LOAD, code, 1'b0, '0, 1'b0, unused);
    endtask

    task automatic send_sample(output logic last_out);
        send_word(REQ_SAMPLE, SYM_W'($urandom_range(0, 255)), 1'b0, '0, 1'b0, last_out);
    endtask

    // register written only with nothing in flight
    task automatic write_packet_length(input logic [PLEN_W-1:0] len);
        @(negedge clk) s_tvalid <= 1'b0;
        while (pending_samples.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= len;
        do
            @(posedge clk);
        while (cfg_ready !== 1'b1);
        pkt_len = len;
        @(negedge clk) cfg_valid <= 1'b0;
    endtask

    task automatic random_phase(input int n_items);
        int   done;
        int   run_len;
        int   pick;
        logic lst;
        done = 0;
        while (done < n_items)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 80)
            begin
                send_load(keypad_keys[$urandom_range(0, keypad_keys.len() - 1)]);
                run_len = $urandom_range(1, 30);
                repeat (run_len) send_sample(lst);
                done += run_len + 1;
            end
            else if (pick < 92)
            begin
                send_load(SYM_W'($urandom_range(0, 255)));
                done++;
            end
            else
            begin
                run_len = $urandom_range(1, 8);
                repeat (run_len) send_sample(lst);
                done += run_len;
            end
        end
    endtask

    initial
    begin
        m_tready = 1'b0;
        forever
            @(negedge clk) m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid === 1'b1 && m_tready === 1'b1)
        begin
            if (pending_samples.size() == 0)
                report_mismatch($sformatf("unexpected sample word %h", m_tdata));
            else
            begin
                oldest_sample = pending_samples.pop_front();
                if (m_tdata !== oldest_sample.level)
                    report_mismatch($sformatf("sample %h, expected %h",
                                              m_tdata, oldest_sample.level));
                if (m_tlast !== oldest_sample.last)
                    report_mismatch($sformatf("tlast %b, expected %b",
                                              m_tlast, oldest_sample.last));
            end
            samples_seen++;
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    initial
    begin
        logic lst;
        rst_n          = 1'b0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        s_tuser        = REQ_LOAD;
        cfg_valid      = 1'b0;
        cfg_data       = '0;
        send_idle_pct  = 12;
        recv_idle_pct  = 61;
        row_sel        = SEL_NONE;
        col_sel        = SEL_NONE;
        row_phase      = '0;
        col_phase      = '0;
        sym_pos        = '0;
        pkt_len        = PLEN_RESET;

        repeat (4) @(posedge clk);
        @(negedge clk) rst_n <= 1'b1;

        foreach (stim_rows[i])
            send_word(stim_rows[i].req, stim_rows[i].code, stim_rows[i].typed,
                      stim_rows[i].level, stim_rows[i].last, lst);

        write_packet_length(16'd1);
        random_phase(80);
        write_packet_length(16'd7);
        random_phase(80);
        write_packet_length(16'd65535);
        random_phase(80);

        send_idle_pct = 61;
        recv_idle_pct = 12;
        write_packet_length(16'd2);
        random_phase(80);
        write_packet_length(PLEN_W'($urandom_range(3, 25)));
        random_phase(80);
        write_packet_length(16'd13);
        random_phase(80);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_packet_length(PLEN_W'($urandom_range(1, 20)));
        random_phase(80);
        write_packet_length(16'd5);
        random_phase(80);
        write_packet_length(16'd1);
        random_phase(80);

        // length dropped below position: position counts on past it
        write_packet_length(16'd100);
        send_load("5");
        repeat (40) send_sample(lst);
        write_packet_length(16'd10);
        repeat (30) send_sample(lst);

        // zero length acts as 65536
        write_packet_length(16'd0);
        send_load("9");
        repeat (30) send_sample(lst);

        @(negedge clk) s_tvalid <= 1'b0;
        while (pending_samples.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (mismatch_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
